// ----- rtl/core/fscan_pkg.sv -----
package fscan_pkg;

   localparam int QueueDepth = 32;
   localparam int TrackBits  = 12;
   localparam int ArrivalBits = 32;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_NOTHING = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ACTIVE_NONE = 2'd0,
      ACTIVE_A    = 2'd1,
      ACTIVE_B    = 2'd2
   } active_type;

   localparam logic REQ_ADD      = 1'b0;
   localparam logic REQ_DISPATCH = 1'b1;

endpackage

// ----- rtl/core/fscan_ram.sv -----
module fscan_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/fscan_disk_request_scheduler.sv -----
// FSCAN disk request scheduler. Issue a transaction by raising start while busy is low;
// req_type selects add (store track and arrival into the inactive queue, sorted by
// track) or dispatch (serve the nearest request in the sweep direction of the active
// queue). Exactly one result per transaction appears on the rsp_ ports for one cycle,
// marked by rsp_strobe, in the first cycle that busy is low again; the receiver cannot
// stall it. Each queue sits in its own RAM with one write port and one registered read
// port, and the logic walks it one entry at a time. A dispatch scans every entry and
// then shifts the tail down over the removed one. A full add or a dispatch with both
// queues empty goes straight to the done state.
// csr_ writes load the start head track and the head at once.
module fscan_disk_request_scheduler #(
   parameter int QUEUE_DEPTH = fscan_pkg::QueueDepth,
   parameter int TRACK_BITS  = fscan_pkg::TrackBits
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_type,
   input  logic [TRACK_BITS-1:0]   req_track,
   input  logic [31:0]             arrival_time,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic                    rsp_out_valid,
   output logic [TRACK_BITS-1:0]   rsp_out_track,
   output logic [31:0]             rsp_out_arrival,
   output logic                    rsp_all_empty,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [TRACK_BITS-1:0]   csr_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = TRACK_BITS + 32;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_SCAN   = 8'b00000010, // read entry
      ST_SCANW  = 8'b00000100, // compare the read entry
      ST_SHIFT  = 8'b00001000, // read entry to move
      ST_SHIFTW = 8'b00010000, // write moved entry
      ST_PICK   = 8'b00100000, // choose direction and selected entry
      ST_PICKW  = 8'b01000000,
      ST_DONE   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0] cnt_ff [2];
   logic [CW-1:0] cnt_in [2];
   fscan_pkg::active_type active_ff, active_in;
   logic down_ff, down_in;
   logic [TRACK_BITS-1:0] head_ff, head_in;
   logic op_ff, op_in;
   logic q_ff, q_in;
   logic [TRACK_BITS-1:0] trk_ff, trk_in;
   logic [31:0] arr_ff, arr_in;
   logic [CW-1:0] idx_ff, idx_in;      // scan / shift position
   logic [CW-1:0] lo_ff, lo_in;        // best candidate index
   logic found_ff, found_in;
   logic [TRACK_BITS-1:0] best_ff, best_in;
   logic [1:0] st_ff, st_in;
   logic ov_ff, ov_in;
   logic [TRACK_BITS-1:0] otrk_ff, otrk_in;
   logic [31:0] oarr_ff, oarr_in;
   logic strobe_ff, strobe_in;

   logic [EW-1:0] wr_data, rd_data [2];
   logic [AW-1:0] wr_addr, rd_addr;
   logic          wr_en [2];
   logic          wr_go;

   for (genvar g = 0; g < 2; g++) begin : g_queue
      fscan_ram #(.Width(EW), .Depth(QUEUE_DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_addr (rd_addr),
         .rd_data (rd_data[g])
      );
      assign wr_en[g] = wr_go && (q_ff == 1'(g));
   end

   logic [EW-1:0] rd_q;
   logic [TRACK_BITS-1:0] rd_trk;
   assign rd_q   = rd_data[q_ff];
   assign rd_trk = rd_q[EW-1:32];

   logic [CW-1:0] n_cur;
   assign n_cur = cnt_ff[q_ff];

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;

   // sequence one transaction
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      down_in   = down_ff;
      head_in   = head_ff;
      op_in     = op_ff;
      q_in      = q_ff;
      trk_in    = trk_ff;
      arr_in    = arr_ff;
      idx_in    = idx_ff;
      lo_in     = lo_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      st_in     = st_ff;
      ov_in     = ov_ff;
      otrk_in   = otrk_ff;
      oarr_in   = oarr_ff;
      strobe_in = 1'b0;
      wr_go     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = {trk_ff, arr_ff};
      rd_addr   = idx_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               head_in = csr_data;
            end
            if (start) begin
               op_in  = req_type;
               trk_in = req_track;
               arr_in = arrival_time;
               st_in  = fscan_pkg::STATUS_OK;
               ov_in  = 1'b0;
               otrk_in = '0;
               oarr_in = '0;
               idx_in  = '0;
               found_in = 1'b0;
               if (req_type == fscan_pkg::REQ_ADD) begin
                  q_in = (active_ff == fscan_pkg::ACTIVE_A);
                  if (cnt_ff[active_ff == fscan_pkg::ACTIVE_A] == CW'(QUEUE_DEPTH)) begin
                     st_in    = fscan_pkg::STATUS_FULL;
                     state_in = ST_DONE;
                  end else begin
                     // find insert point: scan from the top downward
                     idx_in   = cnt_ff[active_ff == fscan_pkg::ACTIVE_A];
                     state_in = ST_SCAN;
                  end
               end else if (cnt_ff[0] == '0 && cnt_ff[1] == '0) begin
                  st_in    = fscan_pkg::STATUS_NOTHING;
                  state_in = ST_DONE;
               end else begin
                  q_in = (active_ff == fscan_pkg::ACTIVE_B);
                  if (cnt_ff[active_ff == fscan_pkg::ACTIVE_B] == '0) begin
                     q_in      = !(active_ff == fscan_pkg::ACTIVE_B);
                     active_in = (active_ff == fscan_pkg::ACTIVE_B) ?
                                 fscan_pkg::ACTIVE_A : fscan_pkg::ACTIVE_B;
                     down_in   = 1'b0;
                  end
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // add: shift-insert walks down from count; dispatch: scan up from 0
            if (op_ff == fscan_pkg::REQ_ADD) begin
               if (idx_ff == '0) begin
                  state_in = ST_PICKW;
               end else begin
                  rd_addr  = AW'(idx_ff - 1'b1);
                  state_in = ST_SCANW;
               end
            end else begin
               if (idx_ff == n_cur) begin
                  state_in = ST_PICK;
               end else begin
                  state_in = ST_SCANW;
               end
            end
         end
         ST_SCANW: begin
            if (op_ff == fscan_pkg::REQ_ADD) begin
               if (rd_trk > trk_ff) begin
                  // move entry up one slot
                  wr_go   = 1'b1;
                  wr_data = rd_q;
                  idx_in  = idx_ff - 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_PICKW;
               end
            end else begin
               // track upward and downward candidates together
               if (!found_ff) begin
                  found_in = 1'b1;
                  best_in  = rd_trk;
                  lo_in    = idx_ff;
               end
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN;
               if (found_ff) begin
                  best_in = best_ff;
               end
               // remember smallest >= head (first index) in otrk_ff/oarr_ff,
               // largest <= head (first of its group) in lo_ff path below
               if (rd_trk >= head_ff && !ov_ff) begin
                  ov_in  = 1'b1;
                  otrk_in = rd_trk;
                  oarr_in = {{(32-CW){1'b0}}, idx_ff};
               end
               if (rd_trk <= head_ff && (!found_ff || rd_trk != best_ff)) begin
                  best_in = rd_trk;
                  lo_in   = idx_ff;
               end else if (!found_ff) begin
                  best_in = rd_trk;
                  lo_in   = idx_ff;
               end
            end
         end
         ST_PICK: begin
            // decide direction and selected index
            found_in = 1'b0;
            if (!down_ff) begin
               if (!ov_ff) begin
                  down_in = 1'b1;
                  idx_in  = lo_ff;
                  head_in = best_ff;
               end else begin
                  idx_in  = oarr_ff[CW-1:0];
                  head_in = otrk_ff;
               end
            end else begin
               if (best_ff > head_ff) begin
                  down_in = 1'b0;
                  idx_in  = oarr_ff[CW-1:0];
                  head_in = otrk_ff;
               end else begin
                  idx_in  = lo_ff;
                  head_in = best_ff;
               end
            end
            ov_in   = 1'b0;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            rd_addr = idx_ff[AW-1:0];
            state_in = ST_SHIFTW;
         end
         ST_SHIFTW: begin
            if (!found_ff) begin
               found_in = 1'b1;
               ov_in    = 1'b1;
               otrk_in  = rd_trk;
               oarr_in  = rd_q[31:0];
            end
            if (found_ff) begin
               wr_go   = 1'b1;
               wr_addr = AW'(idx_ff - 1'b1);
               wr_data = rd_q;
            end
            if (idx_ff + 1'b1 >= n_cur) begin
               cnt_in[q_ff] = n_cur - 1'b1;
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SHIFT;
            end
         end
         ST_PICKW: begin
            // place the new entry at the insert point
            wr_go   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            cnt_in[q_ff] = n_cur + 1'b1;
            if (active_ff == fscan_pkg::ACTIVE_NONE) begin
               active_in = fscan_pkg::ACTIVE_A;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         active_ff <= fscan_pkg::ACTIVE_NONE;
         down_ff   <= 1'b0;
         head_ff   <= '0;
         strobe_ff <= 1'b0;
         found_ff  <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         active_ff <= active_in;
         down_ff   <= down_in;
         head_ff   <= head_in;
         strobe_ff <= strobe_in;
         found_ff  <= found_in;
         ov_ff     <= ov_in;
      end
      op_ff   <= op_in;
      q_ff    <= q_in;
      trk_ff  <= trk_in;
      arr_ff  <= arr_in;
      idx_ff  <= idx_in;
      lo_ff   <= lo_in;
      best_ff <= best_in;
      st_ff   <= st_in;
      otrk_ff <= otrk_in;
      oarr_ff <= oarr_in;
   end

   // result is valid on the strobe cycle and stays until the next start
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = st_ff;
   assign rsp_out_valid   = (st_ff == fscan_pkg::STATUS_OK) && (op_ff == fscan_pkg::REQ_DISPATCH);
   assign rsp_out_track   = rsp_out_valid ? otrk_ff : '0;
   assign rsp_out_arrival = rsp_out_valid ? oarr_ff : '0;
   assign rsp_all_empty   = (cnt_ff[0] == '0) && (cnt_ff[1] == '0);

   // start is accepted only while idle; also strobe never while busy and counts within depth
   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy == 1'b0) else $error("strobe while busy");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= CW'(QUEUE_DEPTH) && cnt_ff[1] <= CW'(QUEUE_DEPTH))
      else $error("count overflow");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept not taken");

endmodule

// ----- sim/fscan_disk_request_scheduler_tb.sv -----
module fscan_disk_request_scheduler_tb;

   typedef logic [fscan_pkg::TrackBits-1:0]   track_type;
   typedef logic [fscan_pkg::ArrivalBits-1:0] arrival_type;

   typedef struct {
      fscan_pkg::status_type status;
      logic                  valid;
      track_type             track;
      arrival_type           arrival;
      logic                  all_empty;
   } disk_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   req_type = fscan_pkg::REQ_ADD;
   track_type              req_track = '0;
   logic [31:0]            arrival_time = '0;
   logic                   rsp_strobe;
   logic [1:0]             rsp_status;
   logic                   rsp_out_valid;
   track_type              rsp_out_track;
   logic [31:0]            rsp_out_arrival;
   logic                   rsp_all_empty;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   track_type              csr_data = '0;

   // scheduler shadow state
   track_type              sched_track [2][fscan_pkg::QueueDepth];
   arrival_type            sched_arrival [2][fscan_pkg::QueueDepth];
   int                     sched_count [2];
   fscan_pkg::active_type  sched_active;
   logic                   sched_down;
   track_type              sched_head;

   disk_result_type pending_results[$];
   int              error_count = 0;
   int              sender_idle_pct = 0;

   fscan_disk_request_scheduler u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_track(req_track), .arrival_time(arrival_time),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_out_valid(rsp_out_valid),
      .rsp_out_track(rsp_out_track), .rsp_out_arrival(rsp_out_arrival),
      .rsp_all_empty(rsp_all_empty),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // insert after equal tracks into the inactive queue
   function automatic disk_result_type schedule_add(track_type trk, arrival_type arr);
      disk_result_type r;
      int q;
      int pos;
      r = '{fscan_pkg::STATUS_OK, 1'b0, '0, '0, 1'b0};
      q = (sched_active == fscan_pkg::ACTIVE_A) ? 1 : 0;
      if (sched_count[q] >= fscan_pkg::QueueDepth) begin
         r.status = fscan_pkg::STATUS_FULL;
      end else begin
         pos = 0;
         while (pos < sched_count[q] && sched_track[q][pos] <= trk) pos++;
         for (int i = sched_count[q]; i > pos; i--) begin
            sched_track[q][i]   = sched_track[q][i-1];
            sched_arrival[q][i] = sched_arrival[q][i-1];
         end
         sched_track[q][pos]   = trk;
         sched_arrival[q][pos] = arr;
         sched_count[q]++;
         if (sched_active == fscan_pkg::ACTIVE_NONE) sched_active = fscan_pkg::ACTIVE_A;
      end
      r.all_empty = (sched_count[0] == 0 && sched_count[1] == 0);
      return r;
   endfunction

   // serve nearest request along the sweep, swapping and reversing as needed
   function automatic disk_result_type schedule_dispatch();
      disk_result_type r;
      int q;
      int n;
      int sel;
      int i;
      r = '{fscan_pkg::STATUS_NOTHING, 1'b0, '0, '0, 1'b0};
      if (sched_count[0] == 0 && sched_count[1] == 0) begin
         r.all_empty = 1'b1;
         return r;
      end
      q = (sched_active == fscan_pkg::ACTIVE_B) ? 1 : 0;
      if (sched_count[q] == 0) begin
         q = 1 - q;
         sched_active = (q == 1) ? fscan_pkg::ACTIVE_B : fscan_pkg::ACTIVE_A;
         sched_down = 1'b0;
      end
      n = sched_count[q];
      if (!sched_down) begin
         if (sched_track[q][n-1] < sched_head) sched_down = 1'b1;
      end else begin
         if (sched_track[q][0] > sched_head) sched_down = 1'b0;
      end
      sel = 0;
      if (!sched_down) begin
         while (sel < n - 1 && sched_track[q][sel] < sched_head) sel++;
      end else begin
         i = n - 1;
         while (i > 0 && sched_track[q][i] > sched_head) i--;
         while (sel < i && sched_track[q][sel] != sched_track[q][i]) sel++;
      end
      r.status  = fscan_pkg::STATUS_OK;
      r.valid   = 1'b1;
      r.track   = sched_track[q][sel];
      r.arrival = sched_arrival[q][sel];
      for (i = sel; i + 1 < n; i++) begin
         sched_track[q][i]   = sched_track[q][i+1];
         sched_arrival[q][i] = sched_arrival[q][i+1];
      end
      sched_count[q] = n - 1;
      sched_head = r.track;
      r.all_empty = (sched_count[0] == 0 && sched_count[1] == 0);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // check each result against the oldest prediction
   always @(posedge clock) begin
      disk_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_out_valid !== want.valid)
               report_mismatch("out_valid", rsp_out_valid, want.valid);
            if (rsp_out_track !== want.track)
               report_mismatch("out_track", rsp_out_track, want.track);
            if (rsp_out_arrival !== want.arrival)
               report_mismatch("out_arrival", rsp_out_arrival, want.arrival);
            if (rsp_all_empty !== want.all_empty)
               report_mismatch("all_empty", rsp_all_empty, want.all_empty);
         end
      end
   end

   // send one transaction; start stays high unless an idle gap follows
   task automatic send_request(logic kind, track_type trk, logic [31:0] arr);
      int gap;
      start        <= 1'b1;
      req_type     <= kind;
      req_track    <= trk;
      arrival_time <= arr;
      do @(posedge clock); while (busy);
      if (kind == fscan_pkg::REQ_ADD) pending_results.push_back(schedule_add(trk, arr));
      else pending_results.push_back(schedule_dispatch());
      if ($urandom_range(99) < sender_idle_pct) begin
         gap = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0 || busy);
   endtask

   task automatic write_start_head(track_type value);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      sched_head = value;
   endtask

   task automatic add_request(track_type trk, logic [31:0] arr);
      send_request(fscan_pkg::REQ_ADD, trk, arr);
   endtask

   task automatic dispatch_request();
      send_request(fscan_pkg::REQ_DISPATCH, track_type'($urandom), $urandom);
   endtask

   // extremes, equal tracks, reversal, swap and empty dispatch
   task automatic test_directed();
      write_start_head(12'd2048);
      dispatch_request();
      add_request(12'd4095, 32'hFFFF_FFFF);
      add_request(12'd0, 32'h0);
      add_request(12'd100, 32'h1);
      add_request(12'd100, 32'h2);
      add_request(12'd3000, 32'hA5A5_5A5A);
      add_request(12'd3000, 32'h5A5A_A5A5);
      dispatch_request();
      dispatch_request();
      add_request(12'd4095, 32'h1234_5678);
      dispatch_request();
      dispatch_request();
      dispatch_request();
      dispatch_request();
      dispatch_request();
      dispatch_request();
      dispatch_request();
      dispatch_request();
      write_start_head(12'd4095);
      add_request(12'd10, 32'h7);
      add_request(12'd4095, 32'h8);
      dispatch_request();
      dispatch_request();
   endtask

   // overflow the inactive queue, then empty both
   task automatic test_queue_full();
      write_start_head(12'd0);
      for (int i = 0; i < fscan_pkg::QueueDepth + 3; i++)
         add_request(track_type'($urandom_range(0, 15)), $urandom);
      for (int i = 0; i < fscan_pkg::QueueDepth + 4; i++) dispatch_request();
   endtask

   // random mix; narrow spans force equal tracks
   task automatic test_random_phase(int items, int add_pct, int span);
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(99) < add_pct)
            add_request(track_type'(span >= 4095 ? $urandom : $urandom_range(0, span)),
                        $urandom);
         else
            dispatch_request();
      end
   endtask

   // hold the sender until every result has arrived, then go on
   task automatic test_drained_pause();
      test_random_phase(20, 60, 4095);
      wait_drained();
      test_random_phase(20, 50, 4095);
   endtask

   initial begin
      sched_count  = '{0, 0};
      sched_active = fscan_pkg::ACTIVE_NONE;
      sched_down   = 1'b0;
      sched_head   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_queue_full();
      sender_idle_pct = 0;
      test_random_phase(100, 55, 4095);
      write_start_head(track_type'($urandom));
      sender_idle_pct = 56;
      test_random_phase(100, 80, 63);
      test_random_phase(40, 30, 63);
      write_start_head(12'd4095);
      sender_idle_pct = 14;
      test_random_phase(100, 50, 4095);
      test_drained_pause();
      write_start_head(12'd0);
      sender_idle_pct = 0;
      test_random_phase(30, 45, 7);
      wait_drained();
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/fscan_pkg.sv
rtl/core/fscan_ram.sv
rtl/core/fscan_disk_request_scheduler.sv
sim/fscan_disk_request_scheduler_tb.sv
